[rtl/fpw_pkg.sv]
// Shared types, constants and the planar palette of the framebuffer pixel writer.
// No dependencies; the core, front, queue and back files refer to it by scoped names.

package fpw_pkg;

    localparam int FIXED_WIDTH = 640;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] MODE_LINEAR32 = 2'd0;
    localparam logic [1:0] MODE_RGB332   = 2'd1;
    localparam logic [1:0] MODE_PACKED24 = 2'd2;
    localparam logic [1:0] MODE_PLANAR4  = 2'd3;

    localparam logic [1:0] CFG_DISPLAY_MODE  = 2'd0;
    localparam logic [1:0] CFG_LINEAR_STRIDE = 2'd1;
    localparam logic [1:0] CFG_SWAP_RED_BLUE = 2'd2;

    localparam logic [13:0] STRIDE_RESET = 14'd640;

    localparam logic [2:0] COUNT_LINEAR  = 3'd4;
    localparam logic [2:0] COUNT_RGB332  = 3'd1;
    localparam logic [2:0] COUNT_PACKED  = 3'd3;
    localparam logic [2:0] COUNT_PLANAR  = 3'd1;

    localparam logic [23:0] PALETTE [16] = '{
        24'h000000, 24'h0000aa, 24'h00aa00, 24'h00aaaa,
        24'haa0000, 24'haa00aa, 24'haa5500, 24'haaaaaa,
        24'h555555, 24'h5555ff, 24'h55ff55, 24'h55ffff,
        24'hff5555, 24'hff55ff, 24'hffff55, 24'hffffff
    };

    localparam logic [7:0] PAL_LEVEL [4] = '{8'h00, 8'h55, 8'haa, 8'hff};

    typedef struct packed {
        logic [27:0] byte_offset;
        logic [31:0] write_data;
        logic [2:0]  byte_count;
        logic [7:0]  bit_mask;
        logic [3:0]  plane_color;
        logic        planar;
    } fpw_item_t;

    function automatic logic [1:0] level_of(input logic [7:0] b);
        logic [1:0] lvl;
        unique case (b)
            8'h55:   lvl = 2'd1;
            8'haa:   lvl = 2'd2;
            8'hff:   lvl = 2'd3;
            default: lvl = 2'd0;
        endcase
        return lvl;
    endfunction

endpackage

[rtl/fpw_if.sv]
// Valid/ready channel interfaces for pixel words in and store words out.
// Depends on nothing.

interface fpw_pixel_if;
    logic        valid;
    logic        ready;
    logic [12:0] pixel_x;
    logic [12:0] pixel_y;
    logic [31:0] rgb_color;

    modport source (output valid, output pixel_x, output pixel_y, output rgb_color,
                    input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input rgb_color,
                    output ready);
endinterface

interface fpw_store_if;
    logic        valid;
    logic        ready;
    logic [27:0] byte_offset;
    logic [31:0] write_data;
    logic [2:0]  byte_count;
    logic [7:0]  bit_mask;
    logic [3:0]  plane_color;
    logic        reload_color;

    modport source (output valid, output byte_offset, output write_data,
                    output byte_count, output bit_mask, output plane_color,
                    output reload_color, input ready);
    modport sink   (input valid, input byte_offset, input write_data,
                    input byte_count, input bit_mask, input plane_color,
                    input reload_color, output ready);
endinterface

[rtl/framebuffer_pixel_writer_core.sv]
// Top level of the framebuffer pixel writer: front, queue and back parts.
// Uses fpw_pkg, fpw_pixel_if, fpw_store_if, fpw_front, fpw_queue, fpw_back.
//
// Takes one pixel word (x, y, colour) per cycle while pixel.ready is high and
// gives one store word per pixel, in order: byte offset, data, byte count, bit
// mask, planar colour index and a reload flag for the planar colour registers.
// Sustained rate is one word per cycle while the output is not stalled. A
// pixel lands in the input register of the five-stage front pipe, four more
// stages follow (address multiply and per-channel differences, squares,
// palette distances, group minima), then it passes through the four-entry
// queue and the output register. Write the configuration only while no pixel
// is in flight; any write to a listed register drops the cached planar colour,
// so the next planar word reloads.

module framebuffer_pixel_writer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [13:0] cfg_data,
    fpw_pixel_if.sink   pixel,
    fpw_store_if.source store
);

    logic               cfg_inval;
    logic               push;
    fpw_pkg::fpw_item_t push_item;
    logic               q_full;
    logic               pop;
    fpw_pkg::fpw_item_t q_item;
    logic               q_not_empty;

    fpw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_inval (cfg_inval),
        .pixel     (pixel),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    fpw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .pop_item  (q_item),
        .not_empty (q_not_empty)
    );

    fpw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_inval   (cfg_inval),
        .q_not_empty (q_not_empty),
        .q_item      (q_item),
        .pop         (pop),
        .store       (store)
    );

endmodule

[rtl/fpw_front.sv]
// Front part: configuration registers, pixel acceptance, address and data
// conversion and the pipelined nearest-palette search. Uses fpw_pkg, fpw_pixel_if.

module fpw_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [13:0]          cfg_data,
    output logic                 cfg_inval,
    fpw_pixel_if.sink            pixel,
    output logic                 push,
    output fpw_pkg::fpw_item_t   push_item,
    input  logic                 q_full
);

    logic [1:0]  mode_reg;
    logic [13:0] stride_reg;
    logic        swap_reg;

    logic        advance;

    logic        s1_valid_reg;
    logic [12:0] s1_x_reg;
    logic [12:0] s1_y_reg;
    logic [31:0] s1_c_reg;

    logic                s2_valid_reg;
    fpw_pkg::fpw_item_t  s2_item_reg;
    fpw_pkg::fpw_item_t  s2_item_next;
    logic [7:0]          s2_adiff_reg [3][4];
    logic [7:0]          s2_adiff_next [3][4];

    logic                s3_valid_reg;
    fpw_pkg::fpw_item_t  s3_item_reg;
    logic [15:0]         s3_sq_reg [3][4];

    logic                s4_valid_reg;
    fpw_pkg::fpw_item_t  s4_item_reg;
    logic [17:0]         s4_dist_reg [16];
    logic [17:0]         s4_dist_next [16];

    logic                s5_valid_reg;
    fpw_pkg::fpw_item_t  s5_item_reg;
    logic [1:0]          s5_sub_reg [4];
    logic [17:0]         s5_best_reg [4];
    logic [1:0]          s5_sub_next [4];
    logic [17:0]         s5_best_next [4];

    logic [3:0]          final_idx;

    // configuration decode
    always_comb
    begin
        unique case (cfg_index)
            fpw_pkg::CFG_DISPLAY_MODE,
            fpw_pkg::CFG_LINEAR_STRIDE,
            fpw_pkg::CFG_SWAP_RED_BLUE: cfg_inval = cfg_we;
            default:                    cfg_inval = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= fpw_pkg::MODE_LINEAR32;
            stride_reg <= fpw_pkg::STRIDE_RESET;
            swap_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fpw_pkg::CFG_DISPLAY_MODE:  mode_reg   <= cfg_data[1:0];
                fpw_pkg::CFG_LINEAR_STRIDE: stride_reg <= cfg_data;
                fpw_pkg::CFG_SWAP_RED_BLUE: swap_reg   <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    // hold the whole pipe while the last stage cannot enter the queue
    assign advance     = !(s5_valid_reg && q_full);
    assign pixel.ready = advance;
    assign push        = s5_valid_reg && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= pixel.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    // stage 2: offset, data, count, mask and per-channel distances to each level
    always_comb
    begin
        logic [27:0] y28;
        logic [27:0] x28;
        logic [7:0]  chan [3];
        y28     = 28'(s1_y_reg);
        x28     = 28'(s1_x_reg);
        chan[0] = s1_c_reg[23:16];
        chan[1] = s1_c_reg[15:8];
        chan[2] = s1_c_reg[7:0];
        s2_item_next.bit_mask    = 8'hff;
        s2_item_next.plane_color = 4'd0;
        s2_item_next.planar      = 1'b0;
        unique case (mode_reg)
            fpw_pkg::MODE_LINEAR32:
            begin
                s2_item_next.byte_offset = (y28 * 28'(stride_reg) + x28) << 2;
                s2_item_next.write_data  = swap_reg ?
                    {8'h00, s1_c_reg[7:0], s1_c_reg[15:8], s1_c_reg[23:16]} : s1_c_reg;
                s2_item_next.byte_count  = fpw_pkg::COUNT_LINEAR;
            end
            fpw_pkg::MODE_RGB332:
            begin
                s2_item_next.byte_offset = y28 * 28'(fpw_pkg::FIXED_WIDTH) + x28;
                s2_item_next.write_data  = {24'h0, s1_c_reg[23:21], s1_c_reg[15:13],
                                            s1_c_reg[7:6]};
                s2_item_next.byte_count  = fpw_pkg::COUNT_RGB332;
            end
            fpw_pkg::MODE_PACKED24:
            begin
                s2_item_next.byte_offset = y28 * 28'(fpw_pkg::FIXED_WIDTH * 3)
                                         + x28 * 28'd3;
                s2_item_next.write_data  = {8'h00, s1_c_reg[23:0]};
                s2_item_next.byte_count  = fpw_pkg::COUNT_PACKED;
            end
            default:
            begin
                s2_item_next.byte_offset = y28 * 28'(fpw_pkg::FIXED_WIDTH / 8)
                                         + 28'(s1_x_reg[12:3]);
                s2_item_next.write_data  = 32'h0000_00ff;
                s2_item_next.byte_count  = fpw_pkg::COUNT_PLANAR;
                s2_item_next.bit_mask    = 8'h80 >> s1_x_reg[2:0];
                s2_item_next.planar      = 1'b1;
            end
        endcase
        for (int ch = 0; ch < 3; ch++)
        begin
            for (int lv = 0; lv < 4; lv++)
            begin
                s2_adiff_next[ch][lv] = (chan[ch] >= fpw_pkg::PAL_LEVEL[lv]) ?
                    chan[ch] - fpw_pkg::PAL_LEVEL[lv] : fpw_pkg::PAL_LEVEL[lv] - chan[ch];
            end
        end
    end

    // stage 4: squared distance to every palette entry
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            s4_dist_next[i] =
                18'(s3_sq_reg[0][fpw_pkg::level_of(fpw_pkg::PALETTE[i][23:16])])
              + 18'(s3_sq_reg[1][fpw_pkg::level_of(fpw_pkg::PALETTE[i][15:8])])
              + 18'(s3_sq_reg[2][fpw_pkg::level_of(fpw_pkg::PALETTE[i][7:0])]);
        end
    end

    // stage 5: best of each group of four, lowest index on ties
    always_comb
    begin
        for (int g = 0; g < 4; g++)
        begin
            s5_sub_next[g]  = 2'd0;
            s5_best_next[g] = s4_dist_reg[4 * g];
            for (int k = 1; k < 4; k++)
            begin
                if (s4_dist_reg[4 * g + k] < s5_best_next[g])
                begin
                    s5_sub_next[g]  = 2'(k);
                    s5_best_next[g] = s4_dist_reg[4 * g + k];
                end
            end
        end
    end

    // final pick across the four groups
    always_comb
    begin
        logic [17:0] best;
        final_idx = {2'd0, s5_sub_reg[0]};
        best      = s5_best_reg[0];
        for (int g = 1; g < 4; g++)
        begin
            if (s5_best_reg[g] < best)
            begin
                final_idx = {2'(g), s5_sub_reg[g]};
                best      = s5_best_reg[g];
            end
        end
        push_item             = s5_item_reg;
        push_item.plane_color = s5_item_reg.planar ? final_idx : 4'd0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_x_reg     <= pixel.pixel_x;
            s1_y_reg     <= pixel.pixel_y;
            s1_c_reg     <= pixel.rgb_color;
            s2_item_reg  <= s2_item_next;
            s2_adiff_reg <= s2_adiff_next;
            s3_item_reg  <= s2_item_reg;
            for (int ch = 0; ch < 3; ch++)
            begin
                for (int lv = 0; lv < 4; lv++)
                begin
                    s3_sq_reg[ch][lv] <= 16'(s2_adiff_reg[ch][lv]) *
                                         16'(s2_adiff_reg[ch][lv]);
                end
            end
            s4_item_reg  <= s3_item_reg;
            s4_dist_reg  <= s4_dist_next;
            s5_item_reg  <= s4_item_reg;
            s5_sub_reg   <= s5_sub_next;
            s5_best_reg  <= s5_best_next;
        end
    end

endmodule

[rtl/fpw_queue.sv]
// Short word queue between the front and back parts.
// Uses fpw_pkg for the item type and depth.

module fpw_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  fpw_pkg::fpw_item_t  push_item,
    output logic                full,
    input  logic                pop,
    output fpw_pkg::fpw_item_t  pop_item,
    output logic                not_empty
);

    fpw_pkg::fpw_item_t                entry_reg [fpw_pkg::QUEUE_DEPTH];
    logic [fpw_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [fpw_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [fpw_pkg::QUEUE_CNT_W-1:0]   count_reg;
    logic [fpw_pkg::QUEUE_CNT_W-1:0]   count_next;

    assign full      = (count_reg == fpw_pkg::QUEUE_CNT_W'(fpw_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/fpw_back.sv]
// Back part: planar colour cache, reload decision and the output register.
// Uses fpw_pkg and fpw_store_if.

module fpw_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_inval,
    input  logic                q_not_empty,
    input  fpw_pkg::fpw_item_t  q_item,
    output logic                pop,
    fpw_store_if.source         store
);

    logic               out_valid_reg;
    fpw_pkg::fpw_item_t out_item_reg;
    logic               out_reload_reg;
    logic               reload_next;
    logic               cache_valid_reg;
    logic [3:0]         cache_index_reg;

    assign pop = q_not_empty && (!out_valid_reg || store.ready);

    assign reload_next = q_item.planar &&
                         (!cache_valid_reg || (cache_index_reg != q_item.plane_color));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            cache_valid_reg <= 1'b0;
            cache_index_reg <= 4'd0;
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (store.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_inval)
            begin
                cache_valid_reg <= 1'b0;
            end
            else if (pop && q_item.planar)
            begin
                cache_valid_reg <= 1'b1;
                cache_index_reg <= q_item.plane_color;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_item_reg   <= q_item;
            out_reload_reg <= reload_next;
        end
    end

    assign store.valid        = out_valid_reg;
    assign store.byte_offset  = out_item_reg.byte_offset;
    assign store.write_data   = out_item_reg.write_data;
    assign store.byte_count   = out_item_reg.byte_count;
    assign store.bit_mask     = out_item_reg.bit_mask;
    assign store.plane_color  = out_item_reg.plane_color;
    assign store.reload_color = out_reload_reg;

endmodule
